### design/swvm_pkg.sv
// Package for the square-wave voice mixer.
// Holds fixed-point constants and register map indexes; no dependencies.
package swvm_pkg;

  // Fixed-point one in Q.16 and the 0.8 gain as a Q0.16 factor
  localparam int unsigned FULL_ONE = 65536;
  localparam int unsigned SCALE_08 = 52429;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_BYTES    = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  // Reset values of the registers
  localparam logic [2:0] BYTES_RST    = 3'd2;
  localparam logic [3:0] CHANNELS_RST = 4'd2;

  // Input word modes
  localparam logic MODE_TRIGGER = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

endpackage

### design/square_wave_voice_mixer.sv
// Square-wave voice mixer, top level.
// Voice state lives in one synchronous RAM; uses swvm_pkg for constants.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item. Mode 0
//   (trigger) loads the first free voice with step, duration and level; it
//   is absorbed in its accept cycle and produces nothing. A zero duration or
//   a full voice table drops it. Mode 1 (tick) mixes one sample frame.
//   A tick walks the voice RAM one entry a cycle (read, then write back the
//   advanced phase and count), then goes through the DRAIN, MUL, SCALE and
//   NEG states for the last write-back, clamp and 0.8 gain, full-scale
//   scaling and negation. The frame leaves on the output channel
//   (out_valid/out_ready) one byte per word, channels in order, each sample
//   little-endian, out_frame_last on the final byte. A tick holds the block
//   through the RAM walk and the byte output, one byte per cycle while the
//   receiver accepts them.
//   in_ready is high only while the sequencer is idle; the last byte may
//   still sit in the output register while the next word is taken.
//   A stalled receiver simply holds the output register; the byte walk waits.
//   Reset clears all voice-active flags and restores the registers
//   (2 bytes per sample, 2 channels). No RAM clearing pass is needed since
//   only entries of active voices are summed or written back.
//   APB: register 0 (addr 0) bytes per sample, register 1 (addr 4) channels.
module square_wave_voice_mixer #(
  parameter int VOICES        = 8,
  parameter int PHASE_BITS    = 24,
  parameter int DURATION_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [23:0] in_phase_step,
  input  logic [19:0] in_duration_samples,
  input  logic [15:0] in_voice_amplitude,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_frame_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ENTRY_W = 2 * PHASE_BITS + DURATION_BITS + 16;
  localparam int SUM_W   = 18 + $clog2(VOICES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_NEG   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  // Clamp rail as a signed value of the accumulator width
  localparam logic signed [SUM_W-1:0] FULL_S = SUM_W'(swvm_pkg::FULL_ONE);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [2:0] bytes_r;
  logic [3:0] chans_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= swvm_pkg::BYTES_RST;
      chans_r <= swvm_pkg::CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        swvm_pkg::REG_BYTES:    bytes_r <= pwdata[2:0];
        swvm_pkg::REG_CHANNELS: chans_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swvm_pkg::REG_BYTES:    prdata = {29'd0, bytes_r};
      swvm_pkg::REG_CHANNELS: prdata = {28'd0, chans_r};
      default:                prdata = '0;
    endcase
  end

  // Effective sample width 1..4 and channel count 1..8
  logic [2:0] nb_eff;
  logic [3:0] nc_eff;

  always_comb begin
    if (bytes_r == 3'd0)      nb_eff = 3'd1;
    else if (bytes_r > 3'd4)  nb_eff = 3'd4;
    else                      nb_eff = bytes_r;
    if (chans_r == 4'd0)      nc_eff = 4'd1;
    else if (chans_r > 4'd8)  nc_eff = 4'd8;
    else                      nc_eff = chans_r;
  end

  // ---------------------------------------------------------------------
  // Sequencer state and input handshake
  // ---------------------------------------------------------------------
  logic [2:0] state_r;
  logic       in_fire;
  logic       trig_fire;
  logic       tick_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign trig_fire = in_fire && (in_mode == swvm_pkg::MODE_TRIGGER);
  assign tick_fire = in_fire && (in_mode == swvm_pkg::MODE_TICK);

  // Trigger fields narrowed or widened to the storage widths
  logic [PHASE_BITS-1:0]    trig_step;
  logic [DURATION_BITS-1:0] trig_dur;

  assign trig_step = PHASE_BITS'(in_phase_step);
  assign trig_dur  = DURATION_BITS'(in_duration_samples);

  // ---------------------------------------------------------------------
  // Voice active flags and first-free search
  // ---------------------------------------------------------------------
  logic [VOICES-1:0] active_r;
  logic              any_free;
  logic [VIDX_W-1:0] free_idx;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        any_free = 1'b1;
        free_idx = VIDX_W'(i);
      end
    end
  end

  logic trig_load;
  assign trig_load = trig_fire && (trig_dur != '0) && any_free;

  // ---------------------------------------------------------------------
  // Voice RAM: {phase, increment, remaining, level}
  // ---------------------------------------------------------------------
  logic [ENTRY_W-1:0] voice_mem [VOICES];
  logic [ENTRY_W-1:0] rdata_r;
  logic [VIDX_W-1:0]  idx_r;
  logic               wb_vld_r;
  logic [VIDX_W-1:0]  wb_idx_r;

  logic               mem_we;
  logic [VIDX_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      voice_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= voice_mem[idx_r];
  end

  // Write-back stage fields
  logic [PHASE_BITS-1:0]    rd_phase;
  logic [PHASE_BITS-1:0]    rd_inc;
  logic [DURATION_BITS-1:0] rd_rem;
  logic [15:0]              rd_lvl;
  logic [PHASE_BITS-1:0]    nx_phase;
  logic [DURATION_BITS-1:0] nx_rem;
  logic                     wb_act;

  assign {rd_phase, rd_inc, rd_rem, rd_lvl} = rdata_r;
  assign nx_phase = rd_phase + rd_inc;
  assign nx_rem   = rd_rem - DURATION_BITS'(1);
  assign wb_act   = wb_vld_r && active_r[wb_idx_r];

  // Trigger writes only while idle, write-back only during the walk and drain
  always_comb begin
    if (trig_load) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd = {{PHASE_BITS{1'b0}}, trig_step, trig_dur, in_voice_amplitude};
    end else begin
      mem_we = wb_act;
      mem_wa = wb_idx_r;
      mem_wd = {nx_phase, rd_inc, nx_rem, rd_lvl};
    end
  end

  // ---------------------------------------------------------------------
  // Mix accumulator and scaling
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] lvl_s;
  logic [16:0]             mag;
  logic                    neg_r;
  logic [32:0]             p1_r;
  logic [31:0]             val_r;
  logic [5:0]              shamt;
  logic [63:0]             wide;

  assign lvl_s = SUM_W'($signed({1'b0, rd_lvl}));

  // Clamp to +/-1.0 and take the magnitude
  always_comb begin
    if (sum_r > FULL_S)
      mag = 17'(swvm_pkg::FULL_ONE);
    else if (sum_r < -FULL_S)
      mag = 17'(swvm_pkg::FULL_ONE);
    else if (sum_r < 0)
      mag = 17'(-sum_r);
    else
      mag = 17'(sum_r);
  end

  // p1 * (2^s - 1) as shift and subtract, s = 8*bytes - 1
  assign shamt = {nb_eff, 3'b000} - 6'd1;
  assign wide  = ({31'd0, p1_r} << shamt) - {31'd0, p1_r};

  // ---------------------------------------------------------------------
  // Output byte walk
  // ---------------------------------------------------------------------
  logic [1:0] byte_k_r;
  logic [2:0] chan_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_free;
  logic       emit_fire;
  logic       last_byte;
  logic       last_chan;

  assign out_free  = !out_valid_r || out_ready;
  assign emit_fire = (state_r == ST_EMIT) && out_free;
  assign last_byte = ({1'b0, byte_k_r} == nb_eff - 3'd1);
  assign last_chan = ({1'b0, chan_r} == nc_eff - 4'd1);

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_byte_r <= 8'(val_r >> {byte_k_r, 3'b000});
      out_last_r <= last_byte && last_chan;
    end
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      idx_r       <= '0;
      wb_vld_r    <= 1'b0;
      wb_idx_r    <= '0;
      sum_r       <= '0;
      byte_k_r    <= '0;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wb_vld_r <= (state_r == ST_WALK);
      wb_idx_r <= idx_r;

      if (trig_load) begin
        active_r[free_idx] <= 1'b1;
      end
      if (wb_act) begin
        sum_r <= rd_phase[PHASE_BITS-1] ? sum_r + lvl_s : sum_r - lvl_s;
        if (nx_rem == '0) begin
          active_r[wb_idx_r] <= 1'b0;
        end
      end

      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (tick_fire) begin
            state_r <= ST_WALK;
            idx_r   <= '0;
            sum_r   <= '0;
          end
        end
        ST_WALK: begin
          if (idx_r == VIDX_W'(VOICES - 1)) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + VIDX_W'(1);
          end
        end
        ST_DRAIN: state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_SCALE;
        ST_SCALE: state_r <= ST_NEG;
        ST_NEG: begin
          state_r  <= ST_EMIT;
          byte_k_r <= '0;
          chan_r   <= '0;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (last_byte) begin
              byte_k_r <= '0;
              if (last_chan) begin
                state_r <= ST_IDLE;
              end else begin
                chan_r <= chan_r + 3'd1;
              end
            end else begin
              byte_k_r <= byte_k_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Scaling datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_MUL: begin
        p1_r  <= 33'(mag) * 33'(swvm_pkg::SCALE_08);
        neg_r <= (sum_r < 0);
      end
      ST_SCALE: val_r <= wide[63:32];
      ST_NEG:   val_r <= neg_r ? (32'd0 - val_r) : val_r;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> state_r == ST_WALK)
    else $error("tick accepted but walk not started");

  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("write-back outside of voice walk");

  a_trig_claims_slot: assert property (@(posedge clk) disable iff (!rst_n)
    trig_load |=> $countones(active_r) == $past($countones(active_r)) + 1)
    else $error("trigger did not claim exactly one voice");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && last_byte && last_chan |=> state_r == ST_IDLE && out_frame_last)
    else $error("frame end not marked or sequencer not idle");

  a_no_ram_clash: assert property (@(posedge clk) disable iff (!rst_n)
    trig_load |-> !wb_vld_r)
    else $error("trigger write collides with voice write-back");

endmodule
